// File: rtl/core/mdir_pkg.sv
`default_nettype none

package mdir_pkg;

   localparam int LINES       = 1024;
   localparam int LINE_BITS   = $clog2(LINES);
   localparam int MAX_SHARERS = 8;
   localparam int COUNT_BITS  = $clog2(MAX_SHARERS + 1);
   localparam int PORT_BITS   = 4;

   typedef logic [1:0]           state_type;
   typedef logic [2:0]           code_type;
   typedef logic [PORT_BITS-1:0] port_type;

   localparam state_type ST_I = 2'd0;
   localparam state_type ST_S = 2'd1;
   localparam state_type ST_E = 2'd2;
   localparam state_type ST_M = 2'd3;

   localparam code_type MK_REQ      = 3'd0;
   localparam code_type MK_REQACK   = 3'd1;
   localparam code_type MK_DISP     = 3'd2;
   localparam code_type MK_SETST    = 3'd3;
   localparam code_type MK_SETSTACK = 3'd4;

   localparam code_type ACT_VALID   = 3'd0;
   localparam code_type ACT_INVALID = 3'd1;
   localparam code_type ACT_DIRTY   = 3'd2;
   localparam code_type ACT_SHARED  = 3'd3;
   localparam code_type ACT_EXCL    = 3'd4;

   typedef struct packed {
      state_type                     local_state;
      state_type                     share_state;
      logic [COUNT_BITS-1:0]         count;
      port_type [MAX_SHARERS-1:0]    sharers;
   } entry_type;

   typedef struct packed {
      logic                          req_type;
      logic [LINE_BITS-1:0]          line_index;
      code_type                      msg_kind;
      code_type                      action;
      logic signed [PORT_BITS:0]     port_id;
      logic                          home_node;
      logic                          ack_with_disp;
   } request_type;

   typedef struct packed {
      logic lower;
      logic higher;
   } notify_type;

endpackage

`default_nettype wire

// File: rtl/core/mdir_channels.sv
`default_nettype none

interface mdir_req_if import mdir_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [LINE_BITS-1:0]      line_index;
   code_type                  msg_kind;
   code_type                  action;
   logic signed [PORT_BITS:0] port_id;
   logic                      home_node;
   logic                      ack_with_disp;

   modport source (output valid, req_type, line_index, msg_kind, action, port_id,
                   home_node, ack_with_disp, input ready);
   modport sink (input valid, req_type, line_index, msg_kind, action, port_id,
                 home_node, ack_with_disp, output ready);
endinterface

interface mdir_rsp_if import mdir_pkg::*; ();
   logic                  valid;
   logic                  ready;
   state_type             line_state;
   state_type             upper_share_state;
   logic [COUNT_BITS-1:0] sharer_total;
   logic                  notify_lower;
   logic                  notify_higher;

   modport source (output valid, line_state, upper_share_state, sharer_total,
                   notify_lower, notify_higher, input ready);
   modport sink (input valid, line_state, upper_share_state, sharer_total,
                 notify_lower, notify_higher, output ready);
endinterface

interface mdir_csr_if ();
   logic valid;
   logic ready;
   logic incoherent_mode;

   modport source (output valid, incoherent_mode, input ready);
   modport sink (input valid, incoherent_mode, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mesi_directory_entry_update.sv
// MESI directory with up to eight sharer pointers per line.
// req_ch carries one directory request per valid/ready handshake: a check
// (flags only) or an apply (flags, then the entry update). rsp_ch returns
// exactly one result per request, in order: the entry after the request and
// the notify flags taken from the entry before it. csr_ch writes the
// incoherent mode bit; it is always ready. The user must write it only while
// idle; the block itself does not enforce this. The accepting edge registers
// the request and the directory read, and the update is loaded into the result
// register once it is empty or its result is taken. Throughput: one request
// per cycle while results are taken, also for back to back requests to the
// same line, which see the previous write through a bypass of the single
// directory write port. After reset a clearing pass writes all 1024 entries,
// one per cycle. req_ch.ready is low until it ends; csr_ch is taken during it.
// When the receiver stalls, the result register holds its request, the
// update stage behind it holds, and req_ch.ready drops once both are full.
`default_nettype none

module mesi_directory_entry_update import mdir_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   mdir_req_if.sink   req_ch,
   mdir_rsp_if.source rsp_ch,
   mdir_csr_if.sink   csr_ch
);

   entry_type            dir_mem [LINES];

   logic                 clearing_ff, clearing_in;
   logic [LINE_BITS-1:0] clr_idx_ff, clr_idx_in;
   logic                 incoherent_ff, incoherent_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   request_type          s1_req_ff;
   entry_type            rd_data_ff;
   logic                 fwd_ff;
   entry_type            fwd_data_ff;

   request_type          req_in;
   logic                 req_fire;
   logic                 s1_move;
   entry_type            cur_entry;
   entry_type            new_entry;
   notify_type           notify;
   logic                 mem_we;
   logic [LINE_BITS-1:0] mem_waddr;
   entry_type            mem_wdata;

   entry_type            rsp_entry_ff;
   notify_type           rsp_notify_ff;

   assign req_in = '{req_type:      req_ch.req_type,
                     line_index:    req_ch.line_index,
                     msg_kind:      req_ch.msg_kind,
                     action:        req_ch.action,
                     port_id:       req_ch.port_id,
                     home_node:     req_ch.home_node,
                     ack_with_disp: req_ch.ack_with_disp};

   assign s1_move      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !clearing_ff && (!s1_valid_ff || s1_move);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // A request read at the edge where the one ahead writes the same line
   // takes the freshly written entry instead of the stale read data.
   assign cur_entry = fwd_ff ? fwd_data_ff : rd_data_ff;

   mdir_entry_update u_update (
      .old_entry       (cur_entry),
      .rq              (s1_req_ff),
      .incoherent_mode (incoherent_ff),
      .new_entry       (new_entry),
      .notify          (notify)
   );

   always_comb begin
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_idx_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = s1_move;
         mem_waddr = s1_req_ff.line_index;
         mem_wdata = new_entry;
      end

      clr_idx_in    = clearing_ff ? clr_idx_ff + LINE_BITS'(1) : clr_idx_ff;
      clearing_in   = clearing_ff && (clr_idx_ff != LINE_BITS'(LINES - 1));
      incoherent_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.incoherent_mode
                                                     : incoherent_ff;
      s1_valid_in   = req_fire || (s1_valid_ff && !s1_move);
      rsp_valid_in  = s1_move || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clr_idx_ff    <= '0;
         incoherent_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clearing_ff   <= clearing_in;
         clr_idx_ff    <= clr_idx_in;
         incoherent_ff <= incoherent_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         dir_mem[mem_waddr] <= mem_wdata;
      end
      if (req_fire) begin
         rd_data_ff <= dir_mem[req_ch.line_index];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff   <= req_in;
         fwd_ff      <= s1_move && (s1_req_ff.line_index == req_ch.line_index);
         fwd_data_ff <= new_entry;
      end
      if (s1_move) begin
         rsp_entry_ff  <= new_entry;
         rsp_notify_ff <= notify;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.line_state        = rsp_entry_ff.local_state;
   assign rsp_ch.upper_share_state = rsp_entry_ff.share_state;
   assign rsp_ch.sharer_total      = rsp_entry_ff.count;
   assign rsp_ch.notify_lower      = rsp_notify_ff.lower;
   assign rsp_ch.notify_higher     = rsp_notify_ff.higher;

endmodule

`default_nettype wire

// File: rtl/core/mdir_entry_update.sv
`default_nettype none

module mdir_entry_update import mdir_pkg::*; (
   input  entry_type   old_entry,
   input  request_type rq,
   input  logic        incoherent_mode,
   output entry_type   new_entry,
   output notify_type  notify
);

   state_type                  old_st;
   state_type                  st;
   logic [COUNT_BITS-1:0]      n;
   logic [COUNT_BITS-1:0]      n_after;
   logic                       has_port;
   port_type                   port;
   logic                       known;
   logic                       full;
   logic [MAX_SHARERS-1:0]     hit;
   logic                       seen;
   port_type [MAX_SHARERS-1:0] shifted;
   port_type [MAX_SHARERS-1:0] rm_list;
   port_type [MAX_SHARERS-1:0] add_list;
   logic                       rm_ok;
   logic                       add_ok;
   logic                       lower_need;
   logic                       higher_need;
   logic                       is_req;
   entry_type                  nx;

   always_comb begin
      old_st   = old_entry.local_state;
      n        = old_entry.count;
      has_port = !rq.port_id[PORT_BITS];
      port     = rq.port_id[PORT_BITS-1:0];
      known    = (rq.msg_kind <= MK_SETSTACK) && (rq.action <= ACT_EXCL);
      is_req   = (rq.msg_kind == MK_REQ) || (rq.msg_kind == MK_REQACK);
      full     = n >= COUNT_BITS'(MAX_SHARERS);

      for (int i = 0; i < MAX_SHARERS; i++) begin
         hit[i] = (COUNT_BITS'(i) < n) && (old_entry.sharers[i] == port);
      end

      // Removal closes the gap left by the first matching sharer.
      shifted = old_entry.sharers >> PORT_BITS;
      seen    = 1'b0;
      for (int j = 0; j < MAX_SHARERS; j++) begin
         seen = seen | hit[j];
         if (seen && (COUNT_BITS'(j) < n)) begin
            rm_list[j] = (COUNT_BITS'(j + 1) < n) ? shifted[j] : '0;
         end else begin
            rm_list[j] = old_entry.sharers[j];
         end
      end
      rm_ok = !full && has_port && (|hit);

      for (int j = 0; j < MAX_SHARERS; j++) begin
         add_list[j] = (COUNT_BITS'(j) == n) ? port : old_entry.sharers[j];
      end
      add_ok = !full && has_port && !(|hit);

      if (incoherent_mode) begin
         lower_need = old_st == ST_I;
      end else begin
         unique case (rq.action)
            ACT_VALID:            lower_need = old_st == ST_I;
            ACT_INVALID:          lower_need = 1'b1;
            ACT_DIRTY, ACT_EXCL:  lower_need = (old_st != ST_M) && (old_st != ST_E);
            ACT_SHARED:           lower_need = (old_st != ST_S) && (old_st != ST_E);
            default:              lower_need = 1'b0;
         endcase
      end

      if (n == '0) begin
         higher_need = 1'b0;
      end else if ((n == COUNT_BITS'(1)) && has_port && (old_entry.sharers[0] == port)) begin
         higher_need = 1'b0;
      end else begin
         unique case (rq.action)
            ACT_VALID, ACT_SHARED:           higher_need = old_entry.share_state != ST_S;
            ACT_INVALID, ACT_DIRTY, ACT_EXCL: higher_need = 1'b1;
            default:                         higher_need = 1'b0;
         endcase
      end

      notify.lower  = known && (rq.msg_kind == MK_REQ) && lower_need;
      notify.higher = known && is_req && !rq.home_node && higher_need;

      unique case (rq.action)
         ACT_VALID:   st = (old_st == ST_I) ? ST_E : old_st;
         ACT_INVALID: st = ST_I;
         ACT_DIRTY:   st = ST_M;
         ACT_SHARED:  st = ST_S;
         default:     st = ST_E;
      endcase

      nx      = old_entry;
      n_after = n;
      if (rq.msg_kind == MK_DISP) begin
         if (rm_ok) begin
            nx.sharers = rm_list;
            nx.count   = n - COUNT_BITS'(1);
            if (n == COUNT_BITS'(1)) begin
               nx.share_state = ST_I;
            end
         end
      end else if (rq.msg_kind == MK_SETSTACK) begin
         if (rq.action == ACT_INVALID) begin
            if (rm_ok) begin
               nx.sharers = rm_list;
               nx.count   = n - COUNT_BITS'(1);
               if (n == COUNT_BITS'(1)) begin
                  nx.share_state = ST_I;
               end
            end
         end else if (old_entry.share_state != ST_I) begin
            nx.share_state = ST_S;
         end
         if (rq.home_node) begin
            st = rq.ack_with_disp ? ST_M : old_st;
         end
      end else if (is_req) begin
         if ((old_st != ST_I) && has_port) begin
            st = old_st;
         end
         if ((rq.msg_kind == MK_REQACK) && !rq.home_node) begin
            if (rq.action == ACT_DIRTY) begin
               st = (old_st == ST_I) ? ST_E : old_st;
            end else if (rq.action == ACT_SHARED) begin
               st = ST_S;
            end else if (rq.action == ACT_EXCL) begin
               st = ST_E;
            end
         end
         if (add_ok) begin
            nx.sharers = add_list;
            n_after    = n + COUNT_BITS'(1);
            nx.count   = n_after;
         end
         if (n_after == '0) begin
            nx.share_state = ST_I;
         end else if (n_after > COUNT_BITS'(1)) begin
            nx.share_state = ST_S;
         end else begin
            nx.share_state = (st == ST_S) ? ST_S : ST_E;
         end
      end
      nx.local_state = st;
      if (st == ST_I) begin
         nx = '0;
      end

      new_entry = (known && rq.req_type) ? nx : old_entry;
   end

endmodule

`default_nettype wire

// File: rtl/core/mdir_checker.sv
`default_nettype none

module mdir_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [9:0] rsp_bits
);

   logic [2:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff + 3'((req_valid && req_ready) ? 1 : 0)
                              - 3'((rsp_valid && rsp_ready) ? 1 : 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // The clearing pass keeps requests out after reset.
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken right after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 3'd0))
      else $error("result shown without an outstanding request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd2)
      else $error("more requests in flight than pipeline stages");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bits))
      else $error("stalled result changed or dropped");

endmodule

bind mesi_directory_entry_update mdir_checker u_mdir_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_bits  ({rsp_ch.line_state, rsp_ch.upper_share_state, rsp_ch.sharer_total,
                rsp_ch.notify_lower, rsp_ch.notify_higher})
);

`default_nettype wire

// File: verif/tb.sv
`default_nettype none

module tb import mdir_pkg::*; ();

   localparam int PID_BITS       = PORT_BITS + 1;
   localparam int MAX_WAIT       = 14;
   // The clearing pass after reset keeps the request channel closed while it clears all LINES entries.
   localparam int WATCHDOG_LIMIT = LINES + 3000;
   // Message kind and action codes beyond the defined ones.
   localparam code_type CODE_SPARE = 3'd5;
   localparam code_type CODE_TOP   = 3'd7;

   typedef struct packed {
      state_type             line_state;
      state_type             share_state;
      logic [COUNT_BITS-1:0] total;
      logic                  lower;
      logic                  higher;
   } entry_result_type;

   logic clock;
   logic reset;

   mdir_req_if req_ch ();
   mdir_rsp_if rsp_ch ();
   mdir_csr_if csr_ch ();

   mesi_directory_entry_update u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Own copy of the directory and of the mode register.
   logic      incoherent;
   state_type dir_local [LINES];
   state_type dir_share [LINES];
   logic [COUNT_BITS-1:0] dir_count [LINES];
   port_type  dir_list [LINES][MAX_SHARERS];

   entry_result_type expected_entries [$];
   request_type      accepted_req;
   entry_result_type accepted_forecast;
   entry_result_type oldest;

   int  error_count;
   int  requests_sent;
   int  results_checked;
   int  broadcast_results;
   int  stall_cycles;
   int  rsp_wait;
   logic quiet;

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic drop_sharer(input int ln, input logic has_port, input port_type port);
      int n;
      int i;
      int hit;
      n = dir_count[ln];
      hit = -1;
      if (n < MAX_SHARERS && has_port) begin
         for (i = 0; i < n; i++)
            if (hit < 0 && dir_list[ln][i] == port) hit = i;
         if (hit >= 0) begin
            for (i = hit; i + 1 < n; i++) dir_list[ln][i] = dir_list[ln][i+1];
            dir_list[ln][n-1] = '0;
            dir_count[ln] = COUNT_BITS'(n - 1);
            if (n == 1) dir_share[ln] = ST_I;
         end
      end
   endtask

   // Works out the flags from the old entry, then, for an apply request with known codes, applies the MESI update.
   task automatic directory_update(input request_type rq, output entry_result_type res);
      int        ln;
      int        n;
      int        i;
      logic      has_port;
      logic      found;
      port_type  port;
      state_type old;
      state_type st;
      logic      nl;
      logic      nh;
      ln = rq.line_index;
      has_port = !rq.port_id[PORT_BITS];
      port = rq.port_id[PORT_BITS-1:0];
      nl = 1'b0;
      nh = 1'b0;
      if (rq.msg_kind <= MK_SETSTACK && rq.action <= ACT_EXCL) begin
         old = dir_local[ln];
         n = dir_count[ln];
         if (rq.msg_kind == MK_REQ) begin
            if (incoherent) nl = (old == ST_I);
            else begin
               case (rq.action)
                  ACT_VALID:   nl = (old == ST_I);
                  ACT_INVALID: nl = 1'b1;
                  ACT_SHARED:  nl = (old != ST_S && old != ST_E);
                  default:     nl = (old != ST_M && old != ST_E);
               endcase
            end
         end
         if ((rq.msg_kind == MK_REQ || rq.msg_kind == MK_REQACK) && !rq.home_node &&
             n != 0 && !(n == 1 && has_port && dir_list[ln][0] == port)) begin
            if (rq.action == ACT_VALID || rq.action == ACT_SHARED)
               nh = (dir_share[ln] != ST_S);
            else
               nh = 1'b1;
         end
         if (rq.req_type) begin
            case (rq.action)
               ACT_VALID:   st = (old == ST_I) ? ST_E : old;
               ACT_INVALID: st = ST_I;
               ACT_DIRTY:   st = ST_M;
               ACT_SHARED:  st = ST_S;
               default:     st = ST_E;
            endcase
            case (rq.msg_kind)
               MK_DISP: begin
                  if (rq.action == ACT_DIRTY) st = ST_M;
                  drop_sharer(ln, has_port, port);
               end
               MK_SETSTACK: begin
                  if (rq.action == ACT_INVALID) drop_sharer(ln, has_port, port);
                  else if (dir_share[ln] != ST_I) dir_share[ln] = ST_S;
                  if (rq.home_node) st = rq.ack_with_disp ? ST_M : old;
               end
               MK_REQ, MK_REQACK: begin
                  if (old != ST_I && has_port) st = old;
                  // An ack from another node with set valid or set invalid keeps st.
                  if (rq.msg_kind == MK_REQACK && !rq.home_node) begin
                     case (rq.action)
                        ACT_DIRTY:  st = (old == ST_I) ? ST_E : old;
                        ACT_SHARED: st = ST_S;
                        ACT_EXCL:   st = ST_E;
                        default: ;
                     endcase
                  end
                  if (n < MAX_SHARERS && has_port) begin
                     found = 1'b0;
                     for (i = 0; i < n; i++)
                        if (dir_list[ln][i] == port) found = 1'b1;
                     if (!found) begin
                        dir_list[ln][n] = port;
                        dir_count[ln] = COUNT_BITS'(n + 1);
                     end
                  end
                  n = dir_count[ln];
                  if (n == 0) dir_share[ln] = ST_I;
                  else if (n > 1) dir_share[ln] = ST_S;
                  else dir_share[ln] = (st == ST_S) ? ST_S : ST_E;
               end
               default: ;
            endcase
            dir_local[ln] = st;
            if (st == ST_I) begin
               dir_share[ln] = ST_I;
               dir_count[ln] = '0;
               for (i = 0; i < MAX_SHARERS; i++) dir_list[ln][i] = '0;
            end
         end
      end
      res.line_state = dir_local[ln];
      res.share_state = dir_share[ln];
      res.total = dir_count[ln];
      res.lower = nl;
      res.higher = nh;
   endtask

   function automatic request_type make_request(input logic apply, input int line,
                                                input code_type kind, input code_type act,
                                                input int port, input logic home,
                                                input logic disp);
      request_type rq;
      rq.req_type = apply;
      rq.line_index = LINE_BITS'(line);
      rq.msg_kind = kind;
      rq.action = act;
      rq.port_id = PID_BITS'(port);
      rq.home_node = home;
      rq.ack_with_disp = disp;
      return rq;
   endfunction

   task automatic send_request(input request_type rq);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= rq.req_type;
      req_ch.line_index <= rq.line_index;
      req_ch.msg_kind <= rq.msg_kind;
      req_ch.action <= rq.action;
      req_ch.port_id <= rq.port_id;
      req_ch.home_node <= rq.home_node;
      req_ch.ack_with_disp <= rq.ack_with_disp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_entries.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input logic value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.incoherent_mode <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      incoherent = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic test_idle_lines();
      send_request(make_request(1'b0, 0, MK_REQ, ACT_VALID, 0, 1'b0, 1'b0));
      send_request(make_request(1'b0, LINES - 1, MK_REQACK, ACT_EXCL, -1, 1'b1, 1'b1));
   endtask

   // Nine distinct ports fill the pointer list, so the last add finds broadcast mode.
   task automatic test_broadcast_entry();
      int i;
      for (i = 0; i < MAX_SHARERS + 1; i++)
         send_request(make_request(1'b1, 7, MK_REQ, (i == 0) ? ACT_VALID : ACT_SHARED,
                                   (i == 0) ? 15 : i - 1, 1'b0, 1'b0));
      send_request(make_request(1'b1, 7, MK_DISP, ACT_DIRTY, 3, 1'b0, 1'b0));
      send_request(make_request(1'b1, 7, MK_SETST, ACT_INVALID, 2, 1'b0, 1'b0));
   endtask

   task automatic test_special_messages();
      send_request(make_request(1'b1, 9, CODE_SPARE, ACT_VALID, 1, 1'b0, 1'b0));
      send_request(make_request(1'b1, 9, MK_REQ, CODE_TOP, 1, 1'b0, 1'b0));
      send_request(make_request(1'b1, 9, MK_REQ, ACT_VALID, -1, 1'b0, 1'b0));
      send_request(make_request(1'b1, 9, MK_REQACK, ACT_VALID, 4, 1'b0, 1'b0));
      send_request(make_request(1'b1, 9, MK_REQACK, ACT_DIRTY, 5, 1'b0, 1'b0));
      send_request(make_request(1'b1, 9, MK_SETSTACK, ACT_DIRTY, 4, 1'b1, 1'b1));
      send_request(make_request(1'b1, 9, MK_DISP, ACT_DIRTY, 5, 1'b0, 1'b0));
      send_request(make_request(1'b1, 9, MK_SETSTACK, ACT_INVALID, 4, 1'b0, 1'b0));
      send_request(make_request(1'b1, 9, MK_REQ, ACT_EXCL, 2, 1'b1, 1'b0));
   endtask

   task automatic test_incoherent_mode();
      wait_idle();
      write_mode(1'b1);
      send_request(make_request(1'b0, 9, MK_REQ, ACT_DIRTY, 3, 1'b0, 1'b0));
      send_request(make_request(1'b0, LINES - 1, MK_REQ, ACT_INVALID, 3, 1'b0, 1'b0));
      send_request(make_request(1'b1, 9, MK_REQACK, ACT_SHARED, 6, 1'b0, 1'b0));
   endtask

   // A handful of hot lines let sharer lists grow into broadcast mode.
   task automatic test_random_traffic(input int count, input logic mode);
      int          k;
      int          r;
      int          line;
      code_type    kind;
      code_type    act;
      request_type rq;
      wait_idle();
      write_mode(mode);
      for (k = 0; k < count; k++) begin
         if (k % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 85) begin
            line = $urandom_range(0, 7);
            if (line >= 4) line = LINES - 8 + line;
         end else
            line = $urandom_range(0, LINES - 1);
         r = $urandom_range(0, 99);
         if (r < 3) kind = code_type'($urandom_range(CODE_SPARE, CODE_TOP));
         else if (r < 38) kind = MK_REQ;
         else if (r < 63) kind = MK_REQACK;
         else if (r < 76) kind = MK_DISP;
         else if (r < 86) kind = MK_SETST;
         else kind = MK_SETSTACK;
         r = $urandom_range(0, 99);
         if (r < 3) act = code_type'($urandom_range(CODE_SPARE, CODE_TOP));
         else if (r < 28) act = ACT_VALID;
         else if (r < 36) act = ACT_INVALID;
         else if (r < 56) act = ACT_DIRTY;
         else if (r < 80) act = ACT_SHARED;
         else act = ACT_EXCL;
         rq = make_request($urandom_range(0, 99) < 85, line, kind, act,
                           ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, 15),
                           $urandom_range(0, 9) < 3, 1'($urandom_range(0, 1)));
         send_request(rq);
      end
      quiet = 1'b0;
   endtask

   // Every accepted request is run through the predictor at once.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         accepted_req.req_type = req_ch.req_type;
         accepted_req.line_index = req_ch.line_index;
         accepted_req.msg_kind = req_ch.msg_kind;
         accepted_req.action = req_ch.action;
         accepted_req.port_id = req_ch.port_id;
         accepted_req.home_node = req_ch.home_node;
         accepted_req.ack_with_disp = req_ch.ack_with_disp;
         directory_update(accepted_req, accepted_forecast);
         expected_entries.push_back(accepted_forecast);
         requests_sent++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_checked++;
         if (expected_entries.size() == 0)
            report_mismatch("result with no request outstanding", 1, 0);
         else begin
            oldest = expected_entries.pop_front();
            if (rsp_ch.line_state !== oldest.line_state)
               report_mismatch("line_state", rsp_ch.line_state, oldest.line_state);
            if (rsp_ch.upper_share_state !== oldest.share_state)
               report_mismatch("upper_share_state", rsp_ch.upper_share_state,
                               oldest.share_state);
            if (rsp_ch.sharer_total !== oldest.total)
               report_mismatch("sharer_total", rsp_ch.sharer_total, oldest.total);
            if (rsp_ch.notify_lower !== oldest.lower)
               report_mismatch("notify_lower", rsp_ch.notify_lower, oldest.lower);
            if (rsp_ch.notify_higher !== oldest.higher)
               report_mismatch("notify_higher", rsp_ch.notify_higher, oldest.higher);
            if (oldest.total == MAX_SHARERS) broadcast_results++;
         end
         rsp_wait = quiet ? 0 : $urandom_range(0, MAX_WAIT);
      end
   end

   always @(negedge clock) begin
      if (rsp_wait > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait--;
      end else
         rsp_ch.ready <= 1'b1;
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                  stall_cycles, expected_entries.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int i;
      int j;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.req_type = 1'b0;
      req_ch.line_index = '0;
      req_ch.msg_kind = MK_REQ;
      req_ch.action = ACT_VALID;
      req_ch.port_id = '0;
      req_ch.home_node = 1'b0;
      req_ch.ack_with_disp = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.incoherent_mode = 1'b0;
      incoherent = 1'b0;
      quiet = 1'b0;
      rsp_wait = 0;
      stall_cycles = 0;
      error_count = 0;
      requests_sent = 0;
      results_checked = 0;
      broadcast_results = 0;
      for (i = 0; i < LINES; i++) begin
         dir_local[i] = ST_I;
         dir_share[i] = ST_I;
         dir_count[i] = '0;
         for (j = 0; j < MAX_SHARERS; j++) dir_list[i][j] = '0;
      end
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      write_mode(1'b0);
      test_idle_lines();
      test_broadcast_entry();
      test_special_messages();
      test_incoherent_mode();
      test_random_traffic(400, 1'b0);
      test_random_traffic(250, 1'b1);
      test_random_traffic(350, 1'b0);
      wait_idle();

      $display("Sent %0d directory requests and checked %0d results in both coherence modes,",
               requests_sent, results_checked);
      $display("%0d of them from entries held in broadcast mode.", broadcast_results);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
